@@ rtl/core/touch_burst_filter_calibrate_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the touch burst filter
// Concurrent assertion wrappers clocked by i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_BURST_FILTER_CALIBRATE_UNIT_DEFINES_SVH
`define TOUCH_BURST_FILTER_CALIBRATE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TBFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbfc assertion failed: same-cycle check");
// The consequent must hold in the cycle after the antecedent.
`define TBFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbfc assertion failed: next-cycle check");
`else
`define TBFC_ASSERT_NOW(lbl, ante, cons)
`define TBFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/tbfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbfc_pkg
// Shared types, widths and codes of the touch burst filter and calibration.
// ----------------------------------------------------------------------------
package tbfc_pkg;

    localparam int W_RAW     = 12;
    localparam int W_SUM     = 16;
    localparam int W_BCNT    = 4;
    localparam int W_KIND    = 2;
    localparam int W_CFG_IDX = 3;
    localparam int BURST_LEN = 10;
    localparam int AVG_SHIFT = 3;

    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;
    localparam int CAL_MAX_X_RST     = 240;
    localparam int CAL_MAX_Y_RST     = 320;

    localparam logic [W_CFG_IDX-1:0] REG_CALIBRATING = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_CAL_MIN_X   = 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_CAL_MAX_X   = 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_CAL_MIN_Y   = 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_CAL_MAX_Y   = 3'd4;

    localparam logic [W_KIND-1:0] EV_DOWN   = 2'd0;
    localparam logic [W_KIND-1:0] EV_MOTION = 2'd1;
    localparam logic [W_KIND-1:0] EV_UP     = 2'd2;
    localparam logic [W_KIND-1:0] EV_CAL    = 2'd3;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef logic [W_RAW-1:0] t_raw;

    typedef struct packed {
        logic       command;
        logic [7:0] x_high_byte;
        logic [7:0] x_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] y_low_byte;
    } t_in_item;

    typedef struct packed {
        logic [W_KIND-1:0] event_kind;
        t_raw              pos_x;
        t_raw              pos_y;
    } t_out_item;

    typedef struct packed {
        logic sample;
        logic clear;
    } t_burst_ctl;

    typedef struct packed {
        logic done;
        t_raw avg_x;
        t_raw avg_y;
    } t_burst_res;

    typedef struct packed {
        logic start;
        t_raw r;
        t_raw lo;
        t_raw hi;
        t_raw size;
    } t_scale_req;

    typedef struct packed {
        logic done;
        t_raw q;
    } t_scale_rsp;

endpackage

@@ rtl/core/tbfc_accum.sv @@
// ----------------------------------------------------------------------------
// tbfc_accum
// Burst accumulator: running sums and extremes of both axes, trimmed average.
// ----------------------------------------------------------------------------
module tbfc_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbfc_pkg::t_burst_ctl i_ctl,
    input  tbfc_pkg::t_raw      i_rx,
    input  tbfc_pkg::t_raw      i_ry,
    output tbfc_pkg::t_burst_res o_res
);

    localparam logic [tbfc_pkg::W_BCNT-1:0] CNT_LAST =
        tbfc_pkg::W_BCNT'(tbfc_pkg::BURST_LEN - 1);

    logic [tbfc_pkg::W_BCNT-1:0] r_count;
    logic [tbfc_pkg::W_SUM-1:0]  r_sum_x, r_sum_y;
    tbfc_pkg::t_raw              r_peak_x, r_floor_x, r_peak_y, r_floor_y;

    logic [tbfc_pkg::W_SUM-1:0]  n_sum_x, n_sum_y;
    tbfc_pkg::t_raw              n_peak_x, n_floor_x, n_peak_y, n_floor_y;
    logic [tbfc_pkg::W_SUM-1:0]  trim_x, trim_y;
    logic                        last;

    always_comb begin
        n_sum_x   = r_sum_x + tbfc_pkg::W_SUM'(i_rx);
        n_sum_y   = r_sum_y + tbfc_pkg::W_SUM'(i_ry);
        n_peak_x  = (i_rx > r_peak_x)  ? i_rx : r_peak_x;
        n_floor_x = (i_rx < r_floor_x) ? i_rx : r_floor_x;
        n_peak_y  = (i_ry > r_peak_y)  ? i_ry : r_peak_y;
        n_floor_y = (i_ry < r_floor_y) ? i_ry : r_floor_y;
        // The burst always contains its own extremes, so the trimmed sum never wraps.
        trim_x = n_sum_x - tbfc_pkg::W_SUM'(n_peak_x) - tbfc_pkg::W_SUM'(n_floor_x);
        trim_y = n_sum_y - tbfc_pkg::W_SUM'(n_peak_y) - tbfc_pkg::W_SUM'(n_floor_y);
        last   = (r_count == CNT_LAST);
    end

    assign o_res.done  = i_ctl.sample && last;
    assign o_res.avg_x = trim_x[tbfc_pkg::AVG_SHIFT +: tbfc_pkg::W_RAW];
    assign o_res.avg_y = trim_y[tbfc_pkg::AVG_SHIFT +: tbfc_pkg::W_RAW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear || (i_ctl.sample && last)) begin
            r_count   <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_peak_x  <= '0;
            r_peak_y  <= '0;
            r_floor_x <= '1;
            r_floor_y <= '1;
        end else if (i_ctl.sample) begin
            r_count   <= r_count + 1'b1;
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_peak_x  <= n_peak_x;
            r_peak_y  <= n_peak_y;
            r_floor_x <= n_floor_x;
            r_floor_y <= n_floor_y;
        end
    end

endmodule

@@ rtl/core/tbfc_scale.sv @@
// ----------------------------------------------------------------------------
// tbfc_scale
// Bit-serial linear scaler: shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
module tbfc_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbfc_pkg::t_scale_req i_req,
    output tbfc_pkg::t_scale_rsp o_rsp
);

    localparam int W       = tbfc_pkg::W_RAW;
    localparam int W_CNT   = $clog2(W);
    localparam logic [W_CNT-1:0] CNT_LAST = W_CNT'(W - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]       r_phase;
    logic [W_CNT-1:0] r_cnt;
    logic [W-1:0]     r_d, r_span, r_size_sr;
    logic [2*W-1:0]   r_acc;
    logic             r_done;
    logic [W-1:0]     r_res;

    logic [W-1:0]     s_d, s_span;
    logic             s_zero, s_clamp;
    logic [2*W-1:0]   mul_acc, div_acc;
    logic [W:0]       div_t, div_diff;
    logic             div_ge;
    logic [W-1:0]     div_rem;

    // Operand setup: either limit order, equal limits give zero.
    always_comb begin
        s_d    = '0;
        s_span = '0;
        s_zero = 1'b1;
        if (i_req.hi > i_req.lo) begin
            s_zero = (i_req.r <= i_req.lo);
            s_d    = i_req.r - i_req.lo;
            s_span = i_req.hi - i_req.lo;
        end else if (i_req.lo > i_req.hi) begin
            s_zero = (i_req.lo <= i_req.r);
            s_d    = i_req.lo - i_req.r;
            s_span = i_req.lo - i_req.hi;
        end
        // A distance of at least the span scales to at least the size.
        s_clamp = (s_d >= s_span);
    end

    always_comb begin
        mul_acc  = {r_acc[2*W-2:0], 1'b0} + (r_size_sr[W-1] ? {{W{1'b0}}, r_d} : '0);
        // The quotient stays below the size, so the upper half starts below the span.
        div_t    = {r_acc[2*W-1:W], r_acc[W-1]};
        div_diff = div_t - {1'b0, r_span};
        div_ge   = (div_t >= {1'b0, r_span});
        div_rem  = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
        div_acc  = {div_rem, r_acc[W-2:0], div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        if (s_zero) begin
                            r_res  <= '0;
                            r_done <= 1'b1;
                        end else if (s_clamp) begin
                            r_res  <= i_req.size;
                            r_done <= 1'b1;
                        end else begin
                            r_d       <= s_d;
                            r_span    <= s_span;
                            r_size_sr <= i_req.size;
                            r_acc     <= '0;
                            r_cnt     <= '0;
                            r_phase   <= PH_MUL;
                        end
                    end
                end
                PH_MUL: begin
                    r_acc     <= mul_acc;
                    r_size_sr <= {r_size_sr[W-2:0], 1'b0};
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_phase <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    r_acc <= div_acc;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_res   <= div_acc[W-1:0];
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_res;

endmodule

@@ rtl/core/touch_burst_filter_calibrate_unit.sv @@
// ----------------------------------------------------------------------------
// touch_burst_filter_calibrate_unit
// Touch panel burst filter with trimmed mean and linear calibration.
// ----------------------------------------------------------------------------
// A raw sample that does not complete a burst of ten and a pen-release item are each
// taken whenever the sequencer is idle and the output register is free; a release puts
// its event in the output register at once. The tenth sample of a burst outside
// calibration mode keeps the input stalled while both axes go one after the other
// through a single bit-serial scaler, each through a start state, shift-add multiply,
// restoring divide and a wait state that collects the answer; an emit state then loads
// the event. An axis whose reading lies at or beyond a limit skips multiply and divide.
// While calibrating, a completed burst only updates the stored position.
// Configuration writes take effect at the next edge and are meant for idle time.
`include "touch_burst_filter_calibrate_unit_defines.svh"

module touch_burst_filter_calibrate_unit #(
    parameter int SCREEN_WIDTH  = tbfc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tbfc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tbfc_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tbfc_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tbfc_pkg::W_CFG_IDX-1:0]  i_cfg_index,
    input  logic [tbfc_pkg::W_RAW-1:0]      i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SX   = 3'd1;
    localparam logic [2:0] ST_WX   = 3'd2;
    localparam logic [2:0] ST_SY   = 3'd3;
    localparam logic [2:0] ST_WY   = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam tbfc_pkg::t_raw SIZE_X = tbfc_pkg::W_RAW'(SCREEN_WIDTH);
    localparam tbfc_pkg::t_raw SIZE_Y = tbfc_pkg::W_RAW'(SCREEN_HEIGHT);

    logic [2:0]          r_state;
    logic                r_calibrating;
    tbfc_pkg::t_raw      r_cal_min_x, r_cal_max_x, r_cal_min_y, r_cal_max_y;
    tbfc_pkg::t_raw      r_last_x, r_last_y, r_avg_x, r_avg_y;
    logic                r_pen_down, r_first;
    logic                r_out_valid;
    tbfc_pkg::t_out_item r_out;

    logic                 out_free, in_accept, is_release, is_sample;
    tbfc_pkg::t_raw       rx, ry;
    tbfc_pkg::t_burst_ctl burst_ctl;
    tbfc_pkg::t_burst_res burst_res;
    tbfc_pkg::t_scale_req scale_req;
    tbfc_pkg::t_scale_rsp scale_rsp;
    logic                 sel_y;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_release = in_accept && (i_in_data.command == tbfc_pkg::CMD_RELEASE);
    assign is_sample  = in_accept && (i_in_data.command == tbfc_pkg::CMD_SAMPLE);

    assign rx = {i_in_data.x_high_byte, i_in_data.x_low_byte[7:4]};
    assign ry = {i_in_data.y_high_byte, i_in_data.y_low_byte[7:4]};

    assign burst_ctl.sample = is_sample;
    assign burst_ctl.clear  = is_release;

    tbfc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (burst_ctl),
        .i_rx    (rx),
        .i_ry    (ry),
        .o_res   (burst_res)
    );

    // The scaler latches its operands on the start cycle only.
    assign sel_y           = (r_state == ST_SY);
    assign scale_req.start = (r_state == ST_SX) || (r_state == ST_SY);
    assign scale_req.r     = sel_y ? r_avg_y     : r_avg_x;
    assign scale_req.lo    = sel_y ? r_cal_min_y : r_cal_min_x;
    assign scale_req.hi    = sel_y ? r_cal_max_y : r_cal_max_x;
    assign scale_req.size  = sel_y ? SIZE_Y      : SIZE_X;

    tbfc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scale_req),
        .o_rsp   (scale_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrating <= 1'b0;
            r_cal_min_x   <= '0;
            r_cal_max_x   <= tbfc_pkg::W_RAW'(tbfc_pkg::CAL_MAX_X_RST);
            r_cal_min_y   <= '0;
            r_cal_max_y   <= tbfc_pkg::W_RAW'(tbfc_pkg::CAL_MAX_Y_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbfc_pkg::REG_CALIBRATING: r_calibrating <= i_cfg_wdata[0];
                tbfc_pkg::REG_CAL_MIN_X:   r_cal_min_x   <= i_cfg_wdata;
                tbfc_pkg::REG_CAL_MAX_X:   r_cal_max_x   <= i_cfg_wdata;
                tbfc_pkg::REG_CAL_MIN_Y:   r_cal_min_y   <= i_cfg_wdata;
                tbfc_pkg::REG_CAL_MAX_Y:   r_cal_max_y   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pen_down  <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (is_release) begin
                        r_pen_down       <= 1'b0;
                        r_out.event_kind <= r_calibrating ? tbfc_pkg::EV_CAL
                                                          : tbfc_pkg::EV_UP;
                        r_out.pos_x      <= r_last_x;
                        r_out.pos_y      <= r_last_y;
                        r_out_valid      <= 1'b1;
                    end else if (burst_res.done) begin
                        if (r_calibrating) begin
                            r_last_x   <= burst_res.avg_x;
                            r_last_y   <= burst_res.avg_y;
                            r_pen_down <= 1'b1;
                        end else begin
                            r_avg_x <= burst_res.avg_x;
                            r_avg_y <= burst_res.avg_y;
                            r_first <= !r_pen_down;
                            r_state <= ST_SX;
                        end
                    end
                end
                ST_SX: r_state <= ST_WX;
                ST_WX: begin
                    if (scale_rsp.done) begin
                        r_last_x <= scale_rsp.q;
                        r_state  <= ST_SY;
                    end
                end
                ST_SY: r_state <= ST_WY;
                ST_WY: begin
                    if (scale_rsp.done) begin
                        r_last_y <= scale_rsp.q;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_pen_down       <= 1'b1;
                        r_out.event_kind <= r_first ? tbfc_pkg::EV_DOWN
                                                    : tbfc_pkg::EV_MOTION;
                        r_out.pos_x      <= r_last_x;
                        r_out.pos_y      <= r_last_y;
                        r_out_valid      <= 1'b1;
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The scaler answers only while the sequencer waits for it.
    `TBFC_ASSERT_NOW(a_scale_done_in_wait, scale_rsp.done, (r_state == ST_WX) || (r_state == ST_WY))
    // The output slot is always empty when a burst result is ready to go out.
    `TBFC_ASSERT_NOW(a_emit_slot_free, r_state == ST_EMIT, !r_out_valid)
    // A release transfer always yields an event on the next cycle.
    `TBFC_ASSERT_NEXT(a_release_emits, is_release, r_out_valid)
    // No scaling starts unless a burst has just completed outside calibration.
    `TBFC_ASSERT_NEXT(a_scale_after_burst, (r_state == ST_IDLE) && !burst_res.done, r_state == ST_IDLE)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch burst filter. It sends bursts of raw
// samples and pen releases under changing calibration limits, with random
// gaps and output stalls, and checks every event against its own predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES = 100;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_REGS      = 5;

    // Mirror of the block: calibration registers, burst accumulators and the
    // queue of touch events still to arrive.
    class touch_event_board;
        bit                  calibrating;
        tbfc_pkg::t_raw      min_x, max_x, min_y, max_y;
        int unsigned         burst_n;
        int unsigned         sum_x, sum_y;
        tbfc_pkg::t_raw      peak_x, floor_x, peak_y, floor_y;
        tbfc_pkg::t_raw      last_x, last_y;
        bit                  pen_down;
        tbfc_pkg::t_out_item pending_events[$];
        int                  mismatch_count;

        function new();
            calibrating    = 1'b0;
            min_x          = '0;
            max_x          = tbfc_pkg::t_raw'(tbfc_pkg::CAL_MAX_X_RST);
            min_y          = '0;
            max_y          = tbfc_pkg::t_raw'(tbfc_pkg::CAL_MAX_Y_RST);
            last_x         = '0;
            last_y         = '0;
            pen_down       = 1'b0;
            mismatch_count = 0;
            clear_burst();
        endfunction

        function void clear_burst();
            burst_n = 0;
            sum_x   = 0;
            sum_y   = 0;
            peak_x  = '0;
            floor_x = '1;
            peak_y  = '0;
            floor_y = '1;
        endfunction

        function void set_reg(logic [tbfc_pkg::W_CFG_IDX-1:0] idx, tbfc_pkg::t_raw val);
            case (idx)
                tbfc_pkg::REG_CALIBRATING: calibrating = val[0];
                tbfc_pkg::REG_CAL_MIN_X:   min_x = val;
                tbfc_pkg::REG_CAL_MAX_X:   max_x = val;
                tbfc_pkg::REG_CAL_MIN_Y:   min_y = val;
                tbfc_pkg::REG_CAL_MAX_Y:   max_y = val;
                default: ;
            endcase
        endfunction

        // Linear map between the two limits, in either order, clamped to size.
        function tbfc_pkg::t_raw map_axis(tbfc_pkg::t_raw r, tbfc_pkg::t_raw lo,
                                          tbfc_pkg::t_raw hi, int unsigned size);
            int unsigned d, span, q;
            if (hi > lo) begin
                if (r <= lo) return '0;
                d    = r - lo;
                span = hi - lo;
            end else if (lo > hi) begin
                if (lo <= r) return '0;
                d    = lo - r;
                span = lo - hi;
            end else begin
                return '0;
            end
            q = (d * size) / span;
            if (q > size) q = size;
            return tbfc_pkg::t_raw'(q);
        endfunction

        function void take_item(tbfc_pkg::t_in_item it);
            tbfc_pkg::t_raw      rx, ry, ax, ay;
            tbfc_pkg::t_out_item ev;
            bit                  first;
            if (it.command == tbfc_pkg::CMD_RELEASE) begin
                clear_burst();
                pen_down      = 1'b0;
                ev.event_kind = calibrating ? tbfc_pkg::EV_CAL : tbfc_pkg::EV_UP;
                ev.pos_x      = last_x;
                ev.pos_y      = last_y;
                pending_events.push_back(ev);
                return;
            end
            rx = {it.x_high_byte, it.x_low_byte[7:4]};
            ry = {it.y_high_byte, it.y_low_byte[7:4]};
            sum_x += rx;
            sum_y += ry;
            if (rx > peak_x)  peak_x  = rx;
            if (rx < floor_x) floor_x = rx;
            if (ry > peak_y)  peak_y  = ry;
            if (ry < floor_y) floor_y = ry;
            burst_n++;
            if (burst_n < tbfc_pkg::BURST_LEN) return;

            ax = tbfc_pkg::t_raw'((sum_x - peak_x - floor_x) >> tbfc_pkg::AVG_SHIFT);
            ay = tbfc_pkg::t_raw'((sum_y - peak_y - floor_y) >> tbfc_pkg::AVG_SHIFT);
            clear_burst();
            if (!calibrating) begin
                ax = map_axis(ax, min_x, max_x, tbfc_pkg::SCREEN_WIDTH_DEF);
                ay = map_axis(ay, min_y, max_y, tbfc_pkg::SCREEN_HEIGHT_DEF);
            end
            last_x   = ax;
            last_y   = ay;
            first    = !pen_down;
            pen_down = 1'b1;
            // While calibrating a finished burst only moves the stored position.
            if (calibrating) return;
            ev.event_kind = first ? tbfc_pkg::EV_DOWN : tbfc_pkg::EV_MOTION;
            ev.pos_x      = last_x;
            ev.pos_y      = last_y;
            pending_events.push_back(ev);
        endfunction

        task flag_mismatch(string what);
            mismatch_count++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task compare_event(tbfc_pkg::t_out_item got);
            tbfc_pkg::t_out_item want;
            if (pending_events.size() == 0) begin
                flag_mismatch($sformatf("unexpected event kind %0d x %0d y %0d",
                                        got.event_kind, got.pos_x, got.pos_y));
                return;
            end
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind)
                flag_mismatch($sformatf("event_kind got %0d want %0d",
                                        got.event_kind, want.event_kind));
            if (got.pos_x !== want.pos_x)
                flag_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                flag_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
        endtask
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    tbfc_pkg::t_in_item             in_data   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tbfc_pkg::W_CFG_IDX-1:0] cfg_index = '0;
    tbfc_pkg::t_raw                 cfg_wdata = '0;
    wire                            in_stall;
    wire                            out_valid;
    tbfc_pkg::t_out_item            out_data;

    // Set for whole phases that run without gaps or stalls.
    bit calm = 1'b0;

    touch_event_board board = new();

    touch_burst_filter_calibrate_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic tbfc_pkg::t_raw jitter(tbfc_pkg::t_raw base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return tbfc_pkg::t_raw'(v);
    endfunction

    // Mostly inside the calibrated span, sometimes at or past the extremes.
    function automatic tbfc_pkg::t_raw pick_reading(tbfc_pkg::t_raw a, tbfc_pkg::t_raw b);
        tbfc_pkg::t_raw lo_r, hi_r;
        int             roll;
        lo_r = (a < b) ? a : b;
        hi_r = (a < b) ? b : a;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll < 4) return tbfc_pkg::t_raw'($urandom);
        return tbfc_pkg::t_raw'($urandom_range(lo_r, hi_r));
    endfunction

    function automatic tbfc_pkg::t_in_item sample_item(tbfc_pkg::t_raw rx, tbfc_pkg::t_raw ry);
        tbfc_pkg::t_in_item it;
        it.command     = tbfc_pkg::CMD_SAMPLE;
        it.x_high_byte = rx[11:4];
        it.x_low_byte  = {rx[3:0], 4'($urandom_range(0, 15))};
        it.y_high_byte = ry[11:4];
        it.y_low_byte  = {ry[3:0], 4'($urandom_range(0, 15))};
        return it;
    endfunction

    function automatic tbfc_pkg::t_in_item release_item();
        tbfc_pkg::t_in_item it;
        {it.x_high_byte, it.x_low_byte, it.y_high_byte, it.y_low_byte} = $urandom;
        it.command = tbfc_pkg::CMD_RELEASE;
        return it;
    endfunction

    // One input transfer; returns at the edge where it was taken.
    task automatic send_item(tbfc_pkg::t_in_item it);
        int gap;
        gap = calm ? 0 : pick_idle();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(posedge clk);
        end while (in_stall);
        board.take_item(it);
    endtask

    task automatic write_reg(logic [tbfc_pkg::W_CFG_IDX-1:0] idx, tbfc_pkg::t_raw val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic wait_idle();
        while (board.pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_phase(int mode);
        tbfc_pkg::t_raw mnx, mxx, mny, mxy, tmp;
        bit             cal;
        cal = 1'b0;
        mnx = tbfc_pkg::t_raw'($urandom_range(0, 2000));
        mxx = tbfc_pkg::t_raw'($urandom_range(mnx + 1, 4095));
        mny = tbfc_pkg::t_raw'($urandom_range(0, 2000));
        mxy = tbfc_pkg::t_raw'($urandom_range(mny + 1, 4095));
        case (mode)
            1: begin
                tmp = mnx; mnx = mxx; mxx = tmp;
                tmp = mny; mny = mxy; mxy = tmp;
            end
            2: begin
                mxx = mnx;
                if ($urandom_range(0, 1)) begin
                    tmp = mny; mny = mxy; mxy = tmp;
                end
            end
            3: begin
                mnx = '0; mxx = '1;
                mny = '1; mxy = '0;
            end
            4: cal = 1'b1;
            5: begin
                cal = 1'($urandom_range(0, 1));
                mnx = tbfc_pkg::t_raw'($urandom);
                mxx = tbfc_pkg::t_raw'($urandom);
                mny = tbfc_pkg::t_raw'($urandom);
                mxy = tbfc_pkg::t_raw'($urandom);
            end
            default: ;
        endcase
        // Writes past the last register must leave everything alone.
        if ($urandom_range(0, 1))
            write_reg(tbfc_pkg::W_CFG_IDX'(NUM_REGS + $urandom_range(0, 2)),
                      tbfc_pkg::t_raw'($urandom));
        write_reg(tbfc_pkg::REG_CALIBRATING, {11'($urandom), cal});
        write_reg(tbfc_pkg::REG_CAL_MIN_X, mnx);
        write_reg(tbfc_pkg::REG_CAL_MAX_X, mxx);
        write_reg(tbfc_pkg::REG_CAL_MIN_Y, mny);
        write_reg(tbfc_pkg::REG_CAL_MAX_Y, mxy);
        cfg_we <= 1'b0;
    endtask

    // A touch is a few full bursts, sometimes with a broken tail, then a
    // release. Now and then noise goes in instead.
    task automatic send_touch(inout int sent);
        tbfc_pkg::t_raw     bx, by;
        tbfc_pkg::t_in_item it;
        int                 spread, total, roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            total = $urandom_range(1, 12);
            repeat (total) begin
                {it.x_high_byte, it.x_low_byte, it.y_high_byte, it.y_low_byte} = $urandom;
                it.command = 1'($urandom_range(0, 1));
                send_item(it);
            end
            sent += total;
            return;
        end
        spread = ($urandom_range(0, 7) == 0) ? 2048 : $urandom_range(0, 64);
        total  = $urandom_range(1, 4) * tbfc_pkg::BURST_LEN;
        if ($urandom_range(0, 5) == 0) total += $urandom_range(1, tbfc_pkg::BURST_LEN - 1);
        bx = pick_reading(board.min_x, board.max_x);
        by = pick_reading(board.min_y, board.max_y);
        for (int n = 0; n < total; n++) begin
            if (n % tbfc_pkg::BURST_LEN == 0) begin
                bx = jitter(bx, 32);
                by = jitter(by, 32);
            end
            send_item(sample_item(jitter(bx, spread), jitter(by, spread)));
        end
        send_item(release_item());
        sent += total + 1;
        // A second release finds the pen already up.
        if (roll == 1) begin
            send_item(release_item());
            sent++;
        end
    endtask

    initial begin : watchdog
        int unsigned cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : sink
        int stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) board.compare_event(out_data);
            if (stall_left > 0) stall_left--;
            else stall_left = calm ? 0 : pick_idle();
            out_stall <= (stall_left > 0);
        end
    end

    initial begin : stimulus
        int sent;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limits: a release with the pen up, a burst pinned at the
        // extremes, a burst of alternating extremes, and a release.
        send_item(release_item());
        repeat (tbfc_pkg::BURST_LEN)
            send_item(tbfc_pkg::t_in_item'{tbfc_pkg::CMD_SAMPLE, 8'hFF, 8'hFF, 8'h00, 8'h0F});
        for (int i = 0; i < tbfc_pkg::BURST_LEN; i++) begin
            if (i % 2 == 0)
                send_item(tbfc_pkg::t_in_item'{tbfc_pkg::CMD_SAMPLE,
                                               8'h00, 8'h0F, 8'hFF, 8'hF0});
            else
                send_item(tbfc_pkg::t_in_item'{tbfc_pkg::CMD_SAMPLE,
                                               8'hFF, 8'hF0, 8'h00, 8'h00});
        end
        send_item(release_item());

        for (int p = 0; p < PHASE_COUNT; p++) begin
            in_valid <= 1'b0;
            wait_idle();
            configure_phase(p % 6);
            calm = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS) send_touch(sent);
        end
        in_valid <= 1'b0;
        wait_idle();

        if (board.mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
